// File: src/cha_pkg.sv
// Shared types, constants and the arctangent table of the compass heading core.
package cha_pkg;

    // Vector width after the 8-bit pre-scale, with headroom for the CORDIC gain.
    localparam int XY_W = 26;
    // Angle accumulator width, degrees in Q16.
    localparam int Z_W = 25;
    // Width of the arctangent table index.
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [Z_W-1:0] Z_QUARTER = 25'sd5898240;   // 90 degrees in Q16

    // Scale factors applied to the Q16 degree angle before a 32-bit rounding shift.
    localparam logic signed [Z_W-1:0] SCALE_DEG = 25'sd6553600;   // 100 * 65536
    localparam logic signed [Z_W-1:0] SCALE_RAD = 25'sd9370165;   // 2^32 * pi / 1440

    localparam int PROD_W = 2 * Z_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 50'sd2147483648;

    // Heading arithmetic width and the turn lengths.
    localparam int H_W = 19;
    localparam logic signed [H_W-1:0] DEG_TURN = 19'sd36000;
    localparam logic signed [H_W-1:0] RAD_TURN = 19'sd51472;

    // Unit selector codes carried on the input user field.
    localparam logic CMD_DEG = 1'b0;
    localparam logic CMD_RAD = 1'b1;

    // Configuration register indexes.
    localparam logic REG_DECL_DEG = 1'b0;
    localparam logic REG_DECL_RAD = 1'b1;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
        logic                   cmd;
    } cha_vec_t;

    // atan(2^-i) in degrees Q16; entries past the table add nothing.
    function automatic logic signed [Z_W-1:0] cha_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        begin
            case (idx)
                5'd0:    a = 25'sd2949120;
                5'd1:    a = 25'sd1740967;
                5'd2:    a = 25'sd919879;
                5'd3:    a = 25'sd466945;
                5'd4:    a = 25'sd234379;
                5'd5:    a = 25'sd117304;
                5'd6:    a = 25'sd58666;
                5'd7:    a = 25'sd29335;
                5'd8:    a = 25'sd14668;
                5'd9:    a = 25'sd7334;
                5'd10:   a = 25'sd3667;
                5'd11:   a = 25'sd1833;
                5'd12:   a = 25'sd917;
                5'd13:   a = 25'sd458;
                5'd14:   a = 25'sd229;
                5'd15:   a = 25'sd115;
                5'd16:   a = 25'sd57;
                5'd17:   a = 25'sd29;
                5'd18:   a = 25'sd14;
                5'd19:   a = 25'sd7;
                5'd20:   a = 25'sd4;
                5'd21:   a = 25'sd2;
                5'd22:   a = 25'sd1;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

// File: src/cha_prerot.sv
// Input stage: pre-scale, quadrant pre-rotation and zero-vector detection.
module cha_prerot
    import cha_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   in_valid,
    input  logic                   cmd,
    input  logic signed [15:0]     field_x,
    input  logic signed [15:0]     field_y,
    output logic                   out_valid,
    output cha_vec_t               out_vec
);

    logic     valid_reg;
    cha_vec_t vec_reg;
    cha_vec_t vec_next;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    always_comb
    begin
        xs = {{(XY_W-24){field_x[15]}}, field_x, 8'd0};
        ys = {{(XY_W-24){field_y[15]}}, field_y, 8'd0};
        vec_next.cmd  = cmd;
        vec_next.zero = (field_x == 16'sd0) && (field_y == 16'sd0);
        if (field_x[15])
        begin
            // Left half plane: turn by a quarter so the CORDIC starts with x >= 0.
            if (!field_y[15])
            begin
                vec_next.x = ys;
                vec_next.y = -xs;
                vec_next.z = Z_QUARTER;
            end
            else
            begin
                vec_next.x = -ys;
                vec_next.y = xs;
                vec_next.z = -Z_QUARTER;
            end
        end
        else
        begin
            vec_next.x = xs;
            vec_next.y = ys;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// File: src/cha_cell.sv
// One CORDIC vectoring cell: a single micro-rotation with its own output register.
module cha_cell
    import cha_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  logic     in_valid,
    input  cha_vec_t in_vec,
    output logic     out_valid,
    output cha_vec_t out_vec
);

    localparam logic signed [Z_W-1:0] ANGLE = cha_atan(ATAN_IDX_W'(STEP));

    logic     valid_reg;
    cha_vec_t vec_reg;
    cha_vec_t vec_next;

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb
    begin
        dx = in_vec.y >>> STEP;
        dy = in_vec.x >>> STEP;
        vec_next = in_vec;
        // Rotate toward the positive x axis; y of zero counts as positive.
        if (!in_vec.y[XY_W-1])
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ANGLE;
        end
        else
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// File: src/cha_post.sv
// Output stages: unit scaling with rounding, declination add and wrap into one turn.
module cha_post
    import cha_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  cha_vec_t           in_vec,
    input  logic signed [15:0] decl_deg,
    input  logic signed [15:0] decl_rad,
    output logic               out_valid,
    output logic [15:0]        heading
);

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     cmd1_reg;
    logic                     cmd2_reg;
    logic                     cmd3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [H_W-1:0]    h_reg;
    logic signed [H_W-1:0]    h_next;
    logic [15:0]              heading_reg;
    logic [15:0]              heading_next;

    logic signed [Z_W-1:0]    z_eff;
    logic signed [Z_W-1:0]    scale;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [16:0]       angle;
    logic signed [15:0]       decl;
    logic signed [H_W-1:0]    turn;
    logic signed [H_W-1:0]    turn2;
    logic signed [H_W-1:0]    wrapped;

    // Stage 1: both units share one multiplier; degrees use 100 * 2^16 so that
    // both round the same way at bit 32.
    always_comb
    begin
        z_eff     = in_vec.zero ? '0 : in_vec.z;
        scale     = (in_vec.cmd == CMD_RAD) ? SCALE_RAD : SCALE_DEG;
        prod_next = z_eff * scale;
    end

    // Stage 2: rounding shift and declination.
    always_comb
    begin
        prod_rnd = prod_reg + ROUND_HALF;
        angle    = prod_rnd[48:32];
        decl     = (cmd1_reg == CMD_RAD) ? decl_rad : decl_deg;
        h_next   = H_W'(angle) + H_W'(decl);
    end

    // Stage 3: the sum lies within two turns either way, so one of four
    // offsets brings it into range.
    always_comb
    begin
        turn  = (cmd2_reg == CMD_RAD) ? RAD_TURN : DEG_TURN;
        turn2 = turn <<< 1;
        if (h_reg < -turn)
            wrapped = h_reg + turn2;
        else if (h_reg < 0)
            wrapped = h_reg + turn;
        else if (h_reg >= turn)
            wrapped = h_reg - turn;
        else
            wrapped = h_reg;
        heading_next = wrapped[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg    <= prod_next;
            cmd1_reg    <= in_vec.cmd;
            h_reg       <= h_next;
            cmd2_reg    <= cmd1_reg;
            heading_reg <= heading_next;
            cmd3_reg    <= cmd2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign heading   = heading_reg;

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid && in_vec.zero |=> prod_reg == '0)
        else $error("zero vector did not give a zero angle");

    a_wrap_span: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (h_reg > -(RAD_TURN <<< 1)) && (h_reg < (RAD_TURN <<< 1)))
        else $error("heading sum outside two turns");

    a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && cmd3_reg == CMD_DEG |-> heading_reg < 16'(DEG_TURN))
        else $error("degree heading out of range");

    a_rad_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && cmd3_reg == CMD_RAD |-> heading_reg < 16'(RAD_TURN))
        else $error("radian heading out of range");

endmodule

// File: src/compass_heading_atan2_core.sv
// Top level of the compass heading core: CORDIC atan2 with declination and wrap.
//
// Input stream: s_axis_tdata carries field_x (bits 15:0) and field_y (bits 31:16),
// both signed magnetometer counts; s_axis_tuser carries the unit selector
// (0 for hundredths of a degree, 1 for radians times 8192).
// Output stream: m_axis_tdata carries the heading, wrapped to 0..35999 or 0..51471.
// Configuration: cfg_we with cfg_addr 0 writes the degree declination, with
// cfg_addr 1 the radian declination; write them while no transaction is in flight.
// The pipeline has one pre-rotation stage, one cell per CORDIC step, and three
// output stages (multiply, declination add, wrap).
// One transaction is accepted per cycle unless the receiver stalls; the pipeline
// is fully unrolled, so throughput of the cell chain is one item per clock.
// Reset clears all valid bits and both declinations to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops until that result is taken.
module compass_heading_atan2_core
    import cha_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // field_x [15:0], field_y [31:16]
    input  logic [0:0]  s_axis_tuser,    // cmd [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // heading [15:0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic               advance;
    logic signed [15:0] decl_deg_reg;
    logic signed [15:0] decl_rad_reg;

    logic     chain_valid [0:CORDIC_STEPS];
    cha_vec_t chain_vec   [0:CORDIC_STEPS];

    assign advance       = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_deg_reg <= '0;
            decl_rad_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr[0])
                REG_DECL_DEG: decl_deg_reg <= cfg_wdata;
                REG_DECL_RAD: decl_rad_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    cha_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_axis_tvalid),
        .cmd       (s_axis_tuser[0]),
        .field_x   (s_axis_tdata[15:0]),
        .field_y   (s_axis_tdata[31:16]),
        .out_valid (chain_valid[0]),
        .out_vec   (chain_vec[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        cha_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    cha_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (chain_valid[CORDIC_STEPS]),
        .in_vec    (chain_vec[CORDIC_STEPS]),
        .decl_deg  (decl_deg_reg),
        .decl_rad  (decl_rad_reg),
        .out_valid (m_axis_tvalid),
        .heading   (m_axis_tdata)
    );

endmodule

// File: tb/sv/tb_compass_heading_atan2_core.sv
// Testbench for the compass heading core: CORDIC atan2 headings checked against a local model.
`timescale 1ns / 100ps

module tb_compass_heading_atan2_core;

    localparam int CORDIC_STEPS   = 16;
    localparam int PIPE_LATENCY   = CORDIC_STEPS + 4;
    localparam int RUN_LIMIT_NS   = 5000000;
    localparam longint TURN_CENTIDEG = 36000;
    localparam longint TURN_RAD_Q13  = 51472;
    localparam longint RAD_SCALE_Q32 = 9370165;
    localparam longint HALF_Q32      = 64'sd2147483648;

    typedef struct {
        logic               unit_sel;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic [15:0]        heading;
    } heading_expect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // field_x [15:0], field_y [31:16]
    logic [0:0]  s_axis_tuser = '0;     // cmd [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // heading [15:0]
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    heading_expect_t    pending_headings[$];
    heading_expect_t    oldest_heading;
    logic signed [15:0] decl_centideg = '0;
    logic signed [15:0] decl_rad_q13 = '0;
    bit                 steady_flow = 1'b0;
    int                 error_count = 0;

    compass_heading_atan2_core #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // atan(2^-i) in degrees Q16; steps past the end of the table add nothing.
    function automatic longint atan_step_q16(input int i);
        longint a;
        case (i)
            0:       a = 2949120;
            1:       a = 1740967;
            2:       a = 919879;
            3:       a = 466945;
            4:       a = 234379;
            5:       a = 117304;
            6:       a = 58666;
            7:       a = 29335;
            8:       a = 14668;
            9:       a = 7334;
            10:      a = 3667;
            11:      a = 1833;
            12:      a = 917;
            13:      a = 458;
            14:      a = 229;
            15:      a = 115;
            16:      a = 57;
            17:      a = 29;
            18:      a = 14;
            19:      a = 7;
            20:      a = 4;
            21:      a = 2;
            22:      a = 1;
            default: a = 0;
        endcase
        return a;
    endfunction

    function automatic logic [15:0] predict_heading(input logic unit_sel,
                                                    input logic signed [15:0] fx,
                                                    input logic signed [15:0] fy);
        longint vx;
        longint vy;
        longint ang;
        longint dx;
        longint dy;
        longint h;
        int     i;
        vx = fx;
        vy = fy;
        ang = 0;
        if (vx != 0 || vy != 0)
        begin
            vx = vx * 256;
            vy = vy * 256;
            // Left half plane: rotate by a quarter turn so the CORDIC converges.
            if (vx < 0)
            begin
                dx = vx;
                if (vy >= 0)
                begin
                    vx = vy;
                    vy = -dx;
                    ang = 90 * 65536;
                end
                else
                begin
                    vx = -vy;
                    vy = dx;
                    ang = -90 * 65536;
                end
            end
            for (i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0)
                begin
                    vx = vx + dx;
                    vy = vy - dy;
                    ang = ang + atan_step_q16(i);
                end
                else
                begin
                    vx = vx - dx;
                    vy = vy + dy;
                    ang = ang - atan_step_q16(i);
                end
            end
        end
        if (unit_sel == cha_pkg::CMD_DEG)
        begin
            h = ((ang * 100 + 32768) >>> 16) + longint'(decl_centideg);
            h = h % TURN_CENTIDEG;
            if (h < 0)
                h = h + TURN_CENTIDEG;
        end
        else
        begin
            h = ((ang * RAD_SCALE_Q32 + HALF_Q32) >>> 32) + longint'(decl_rad_q13);
            h = h % TURN_RAD_Q13;
            if (h < 0)
                h = h + TURN_RAD_Q13;
        end
        return h[15:0];
    endfunction

    function automatic logic signed [15:0] pick_field_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return 16'($urandom);
        if (sel < 8)
            return 16'($urandom_range(512) - 256);
        if (sel == 8)
            return 16'sd0;
        return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endfunction

    function automatic logic signed [15:0] pick_declination(input int turn_half, input bit wide);
        if (wide)
            return 16'($urandom);
        return 16'($urandom_range(2 * turn_half) - turn_half);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    // Sends one sample and records its expected heading once the transaction completes.
    task automatic send_sample(input logic unit_sel, input logic signed [15:0] fx,
                               input logic signed [15:0] fy);
        heading_expect_t e;
        while (!steady_flow && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fy, fx};
        s_axis_tuser  <= unit_sel;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        e.unit_sel = unit_sel;
        e.fx = fx;
        e.fy = fy;
        e.heading = predict_heading(unit_sel, fx, fy);
        pending_headings.push_back(e);
    endtask

    // Drops valid and waits until every expected heading has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Writes both declinations back to back; only called while the pipeline is empty.
    task automatic set_declinations(input logic signed [15:0] deg_val,
                                    input logic signed [15:0] rad_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= cha_pkg::REG_DECL_DEG;
        cfg_wdata <= deg_val;
        @(posedge clk);
        cfg_addr  <= cha_pkg::REG_DECL_RAD;
        cfg_wdata <= rad_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        decl_centideg = deg_val;
        decl_rad_q13  = rad_val;
    endtask

    always @(posedge clk)
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 37);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_headings.size() == 0)
            begin
                report_mismatch($sformatf("heading %0d with no sample outstanding", m_axis_tdata));
            end
            else
            begin
                oldest_heading = pending_headings.pop_front();
                if (m_axis_tdata !== oldest_heading.heading)
                    report_mismatch($sformatf("heading unit=%0d x=%0d y=%0d got %0d want %0d",
                                              oldest_heading.unit_sel, oldest_heading.fx,
                                              oldest_heading.fy, m_axis_tdata,
                                              oldest_heading.heading));
            end
        end
    end

    // Axis extremes, the zero vector and the left-half-plane rotation, in both units.
    task automatic test_axis_extremes();
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        int k;
        int u;
        for (k = 0; k < 12; k++)
        begin
            case (k)
                0:       begin fx = 16'sd0;      fy = 16'sd0;      end
                1:       begin fx = 16'sh7fff;   fy = 16'sd0;      end
                2:       begin fx = 16'sh8000;   fy = 16'sd0;      end
                3:       begin fx = 16'sd0;      fy = 16'sh7fff;   end
                4:       begin fx = 16'sd0;      fy = 16'sh8000;   end
                5:       begin fx = 16'sh7fff;   fy = 16'sh7fff;   end
                6:       begin fx = 16'sh8000;   fy = 16'sh8000;   end
                7:       begin fx = 16'sh8000;   fy = 16'sh7fff;   end
                8:       begin fx = 16'sh7fff;   fy = 16'sh8000;   end
                9:       begin fx = -16'sd1;     fy = 16'sd0;      end
                10:      begin fx = -16'sd1;     fy = -16'sd1;     end
                default: begin fx = 16'sd1;      fy = -16'sd1;     end
            endcase
            for (u = 0; u < 2; u++)
                send_sample(u ? cha_pkg::CMD_RAD : cha_pkg::CMD_DEG, fx, fy);
        end
        settle();
    endtask

    // Declination extremes, including values beyond the stated range, with wrap in both units.
    task automatic test_declination_settings();
        logic signed [15:0] deg_val;
        logic signed [15:0] rad_val;
        int k;
        int n;
        for (k = 0; k < 6; k++)
        begin
            case (k)
                0:       begin deg_val = -16'sd18000; rad_val = -16'sd25736; end
                1:       begin deg_val = 16'sd18000;  rad_val = 16'sd25736;  end
                2:       begin deg_val = 16'sh7fff;   rad_val = 16'sh8000;   end
                3:       begin deg_val = 16'sh8000;   rad_val = 16'sh7fff;   end
                4:       begin deg_val = 16'sd0;      rad_val = 16'sd0;      end
                default:
                begin
                    deg_val = pick_declination(18000, 1'b0);
                    rad_val = pick_declination(25736, 1'b0);
                end
            endcase
            set_declinations(deg_val, rad_val);
            send_sample(cha_pkg::CMD_DEG, 16'sd0, 16'sd0);
            send_sample(cha_pkg::CMD_RAD, 16'sd0, 16'sd0);
            for (n = 0; n < 8; n++)
                send_sample(1'($urandom_range(1)), pick_field_value(), pick_field_value());
            settle();
        end
    endtask

    // Random samples in phases, with fresh declinations between phases.
    task automatic test_random_headings();
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++)
        begin
            set_declinations(pick_declination(18000, phase == 3),
                             pick_declination(25736, phase == 3));
            steady_flow = (phase == 1);
            for (n = 0; n < 300; n++)
            begin
                send_sample(1'($urandom_range(1)), pick_field_value(), pick_field_value());
                // Let the pipeline run dry once mid-stream, then resume after a hold-off.
                if (phase == 2 && n == 150)
                begin
                    settle();
                    repeat ($urandom_range(5, 30)) @(posedge clk);
                end
            end
            settle();
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_axis_extremes();
        test_declination_settings();
        test_random_headings();
        settle();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
